// ===== rtl/lmtc_pkg.sv =====
// Package for the LCD mode timing controller: sequencer state type, item kinds,
// display modes, timing constants and field widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lmtc_pkg;

    // Field widths
    localparam int KIND_W  = 2;
    localparam int EL_W    = 6;
    localparam int BYTE_W  = 8;
    localparam int EN_W    = 4;
    localparam int MODE_W  = 2;
    localparam int EV_W    = 6;
    localparam int CD_W    = 10;   // countdown, signed, with headroom below -256
    localparam int AMT_W   = 8;
    localparam int STEP_W  = 4;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    // Countdown reload amounts
    localparam logic [AMT_W-1:0] CYC_LINE     = 8'd228;
    localparam logic [AMT_W-1:0] CYC_OAM      = 8'd40;
    localparam logic [AMT_W-1:0] CYC_XFER     = 8'd86;
    localparam logic [AMT_W-1:0] CYC_HBLANK   = 8'd102;
    localparam logic [AMT_W-1:0] CYC_VB_ENTRY = 8'd8;
    localparam logic [AMT_W-1:0] CYC_LY152    = 8'd28;
    localparam logic [AMT_W-1:0] CYC_LY153    = 8'd200;

    localparam logic signed [CD_W-1:0] CD_RESET   = 10'sd40;
    localparam logic signed [CD_W-1:0] CD_SAT_MIN = -10'sd256;

    // Line numbers
    localparam logic [BYTE_W-1:0] LY_VBLANK  = 8'h90;
    localparam logic [BYTE_W-1:0] LY_SHORT   = 8'd152;
    localparam logic [BYTE_W-1:0] LY_WRAP    = 8'd154;
    localparam logic [BYTE_W-1:0] LY_OFF_OAM = 8'd77;
    localparam logic [BYTE_W-1:0] LY_MAX     = 8'd153;

    localparam logic [BYTE_W-1:0] STAT_EN_MASK = 8'h78;
    localparam int                MAX_STEPS    = 8;

    // Event vector bit positions
    localparam int EV_STAT   = 0;
    localparam int EV_VBLANK = 1;
    localparam int EV_RENDER = 2;
    localparam int EV_FBEGIN = 3;
    localparam int EV_HDMA   = 4;
    localparam int EV_FDONE  = 5;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK = 2'd0,
        KIND_LCDC = 2'd1,
        KIND_STAT = 2'd2,
        KIND_LYC  = 2'd3
    } kind_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_XFER   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUB,
        ST_STEP,
        ST_WRITE
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/lcd_mode_timing_controller.sv =====
// LCD mode timing controller top level: sequencer, shared countdown adder,
// result register and APB configuration port. Depends on lmtc_pkg.
`timescale 1ns / 1ps
`default_nettype none

// An item is taken only while the sequencer is idle. A register write item
// passes through the write state; a tick passes through the subtract state and
// then one step per mode transition it causes (one result each, at least one
// result), up to MAX_STEPS transitions. The single countdown adder does the
// subtract and then each reload in turn.
// Results wait in one output register; a stalled output holds the sequencer.
module lcd_mode_timing_controller
    import lmtc_pkg::*;
(
    input  wire                  aclk,
    input  wire                  aresetn,
    // configuration
    input  wire                  psel,
    input  wire                  penable,
    input  wire                  pwrite,
    input  wire  [2:0]           paddr,
    input  wire  [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    // input items
    input  wire                  s_tvalid,
    output logic                 s_tready,
    input  wire  [S_TDATA_W-1:0] s_tdata,  // elapsed_cycles[5:0], write_value[13:6],
                                           // hdma_active[14], zero[15]
    input  wire  [KIND_W-1:0]    s_tuser,  // kind[1:0]
    // results
    output logic                 m_tvalid,
    input  wire                  m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // stat_irq[0], vblank_irq[1], render_line[2],
                                           // frame_begin[3], hdma_step[4], frame_done[5],
                                           // line_number[13:6], status_value[21:14],
                                           // zero[23:22]
    output logic                 m_tlast
);

    state_t                   state_reg, state_next;
    logic                     color_reg;
    logic [BYTE_W-1:0]        line_reg, line_next;
    logic [MODE_W-1:0]        mode_reg, mode_next;
    logic [EN_W-1:0]          en_reg, en_next;
    logic [BYTE_W-1:0]        ctrl_reg, ctrl_next;
    logic [BYTE_W-1:0]        lyc_reg, lyc_next;
    logic signed [CD_W-1:0]   cd_reg, cd_next;
    logic                     vbp_reg, vbp_next;
    logic [STEP_W-1:0]        step_reg, step_next;

    // latched item
    logic [KIND_W-1:0]        kind_reg;
    logic [EL_W-1:0]          el_reg;
    logic [BYTE_W-1:0]        wval_reg;
    logic                     hdma_reg;

    // result register
    logic                     m_valid_reg, m_valid_next;
    logic [EV_W-1:0]          ev_out_reg, ev_out_next;
    logic [BYTE_W-1:0]        ln_out_reg, ln_out_next;
    logic [BYTE_W-1:0]        st_out_reg, st_out_next;
    logic                     last_out_reg, last_out_next;

    // transition logic
    logic [BYTE_W-1:0]        t_line, line_inc;
    logic [MODE_W-1:0]        t_mode;
    logic                     t_vbp;
    logic [EV_W-1:0]          t_ev;
    logic [AMT_W-1:0]         t_amt;
    logic                     lyc_hit;

    // shared adder
    logic signed [CD_W-1:0]   addend, sum;
    logic                     out_free, s_acc, cfg_wr, more;
    logic [STEP_W-1:0]        step_inc;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == 1'b0) ? {31'd0, color_reg} : 32'd0;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tlast  = last_out_reg;
    assign m_tdata  = {2'b00, st_out_reg, ln_out_reg, ev_out_reg};

    assign line_inc = line_reg + 8'd1;
    assign step_inc = step_reg + STEP_W'(1);

    // one adder: subtract elapsed cycles, or add the reload amount
    always_comb begin
        if (state_reg == ST_SUB) begin
            addend = -$signed({{(CD_W-EL_W){1'b0}}, el_reg});
        end else begin
            addend = $signed({{(CD_W-AMT_W){1'b0}}, t_amt});
        end
    end
    assign sum = cd_reg + addend;

    // one mode transition from the current state
    always_comb begin
        t_line  = line_reg;
        t_mode  = mode_reg;
        t_vbp   = vbp_reg;
        t_ev    = '0;
        t_amt   = CYC_LINE;
        lyc_hit = 1'b0;
        if (!ctrl_reg[7]) begin
            // display off: LY steps every line time
            t_mode = (line_inc > LY_OFF_OAM) ? MODE_OAM : MODE_HBLANK;
            t_line = line_inc;
            if (line_inc >= LY_WRAP) begin
                t_line           = '0;
                t_ev[EV_FBEGIN]  = 1'b1;
                t_ev[EV_FDONE]   = 1'b1;
            end
        end else begin
            case (mode_reg)
                MODE_HBLANK: begin
                    t_line  = line_inc;
                    lyc_hit = (line_inc == lyc_reg);
                    if (line_inc == LY_VBLANK) begin
                        t_mode = MODE_VBLANK;
                        t_vbp  = 1'b1;
                        t_amt  = CYC_VB_ENTRY;
                        t_ev[EV_STAT] = en_reg[1];
                    end else begin
                        t_mode = MODE_OAM;
                        t_amt  = CYC_OAM;
                        t_ev[EV_STAT] = en_reg[2];
                    end
                end
                MODE_VBLANK: begin
                    if (vbp_reg) begin
                        t_ev[EV_VBLANK] = 1'b1;
                        t_vbp           = 1'b0;
                    end else if (line_reg == '0) begin
                        t_mode          = MODE_OAM;
                        t_amt           = CYC_OAM;
                        t_ev[EV_FBEGIN] = 1'b1;
                        t_ev[EV_STAT]   = en_reg[2];
                    end else begin
                        if (line_reg < LY_SHORT) begin
                            t_line = line_inc;
                        end else if (line_reg == LY_SHORT) begin
                            t_amt  = CYC_LY152;
                            t_line = line_inc;
                        end else begin
                            t_amt          = CYC_LY153;
                            t_line         = '0;
                            t_ev[EV_FDONE] = 1'b1;
                        end
                        lyc_hit       = (t_line == lyc_reg);
                        t_ev[EV_STAT] = en_reg[1];
                    end
                end
                MODE_OAM: begin
                    t_mode          = MODE_XFER;
                    t_amt           = CYC_XFER;
                    t_ev[EV_RENDER] = 1'b1;
                end
                default: begin
                    t_mode        = MODE_HBLANK;
                    t_amt         = CYC_HBLANK;
                    t_ev[EV_STAT] = en_reg[0];
                    t_ev[EV_HDMA] = hdma_reg;
                end
            endcase
            if (en_reg[3] && lyc_hit) begin
                t_ev[EV_STAT] = 1'b1;
            end
        end
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        line_next     = line_reg;
        mode_next     = mode_reg;
        en_next       = en_reg;
        ctrl_next     = ctrl_reg;
        lyc_next      = lyc_reg;
        cd_next       = cd_reg;
        vbp_next      = vbp_reg;
        step_next     = step_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        ev_out_next   = ev_out_reg;
        ln_out_next   = ln_out_reg;
        st_out_next   = st_out_reg;
        last_out_next = last_out_reg;
        more          = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                step_next = '0;
                if (s_acc) begin
                    state_next = (s_tuser == KIND_TICK) ? ST_SUB : ST_WRITE;
                end
            end
            ST_SUB: begin
                cd_next    = (sum < CD_SAT_MIN) ? CD_SAT_MIN : sum;
                state_next = ST_STEP;
            end
            ST_STEP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (cd_reg <= 0 && step_reg < STEP_W'(MAX_STEPS)) begin
                        line_next     = t_line;
                        mode_next     = t_mode;
                        vbp_next      = t_vbp;
                        cd_next       = sum;
                        step_next     = step_inc;
                        more          = (sum <= 0) && (step_inc < STEP_W'(MAX_STEPS));
                        ev_out_next   = t_ev;
                        ln_out_next   = t_line;
                        st_out_next   = {1'b1, en_reg, 1'b0, t_mode};
                        last_out_next = !more;
                        if (!more) begin
                            state_next = ST_IDLE;
                        end
                    end else begin
                        // tick with no transition
                        ev_out_next   = '0;
                        ln_out_next   = line_reg;
                        st_out_next   = {1'b1, en_reg, 1'b0, mode_reg};
                        last_out_next = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
            end
            ST_WRITE: begin
                if (out_free) begin
                    ev_out_next = '0;
                    case (kind_reg)
                        KIND_LCDC: begin
                            if (wval_reg[7] && !ctrl_reg[7]) begin
                                mode_next = MODE_OAM;
                                line_next = '0;
                                ev_out_next[EV_FBEGIN] = 1'b1;
                            end else if (!wval_reg[7] && ctrl_reg[7]) begin
                                mode_next = MODE_HBLANK;
                                line_next = '0;
                                ev_out_next[EV_FBEGIN] = 1'b1;
                            end
                            ctrl_next = wval_reg;
                        end
                        KIND_STAT: begin
                            en_next = EN_W'((wval_reg & STAT_EN_MASK) >> 3);
                            // monochrome quirk: any STAT write in vblank off line 0 interrupts
                            if (!color_reg && ctrl_reg[7] && mode_reg == MODE_VBLANK
                                && line_reg != '0) begin
                                ev_out_next[EV_STAT] = 1'b1;
                            end
                            if (line_reg == '0 && lyc_reg == '0 && wval_reg[6]) begin
                                ev_out_next[EV_STAT] = 1'b1;
                            end
                        end
                        KIND_LYC: begin
                            lyc_next = wval_reg;
                        end
                        default: begin
                        end
                    endcase
                    m_valid_next  = 1'b1;
                    ln_out_next   = line_next;
                    st_out_next   = {1'b1, en_next, 1'b0, mode_next};
                    last_out_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            color_reg   <= 1'b0;
            line_reg    <= '0;
            mode_reg    <= MODE_OAM;
            en_reg      <= '0;
            ctrl_reg    <= '0;
            lyc_reg     <= '0;
            cd_reg      <= CD_RESET;
            vbp_reg     <= 1'b0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            line_reg    <= line_next;
            mode_reg    <= mode_next;
            en_reg      <= en_next;
            ctrl_reg    <= ctrl_next;
            lyc_reg     <= lyc_next;
            cd_reg      <= cd_next;
            vbp_reg     <= vbp_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr && paddr[2] == 1'b0) begin
                color_reg <= pwdata[0];
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            kind_reg <= s_tuser;
            el_reg   <= s_tdata[EL_W-1:0];
            wval_reg <= s_tdata[EL_W +: BYTE_W];
            hdma_reg <= s_tdata[EL_W+BYTE_W];
        end
        ev_out_reg   <= ev_out_next;
        ln_out_reg   <= ln_out_next;
        st_out_reg   <= st_out_next;
        last_out_reg <= last_out_next;
    end

    // checks
    a_idle_cd_positive: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (cd_reg > 0))
        else $error("countdown not positive while idle");

    a_line_range: assert property (@(posedge aclk) disable iff (!aresetn)
        line_reg <= LY_MAX)
        else $error("line count out of range");

    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg <= STEP_W'(MAX_STEPS))
        else $error("transition count beyond bound");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> !s_tready)
        else $error("sequencer ready right after taking an item");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for lcd_mode_timing_controller: a cycle-free predictor of the
// LCD mode sequencer feeds an in-order result check on the m_ stream. Needs lmtc_pkg.
`timescale 1ns / 1ps

module tb_top;
    import lmtc_pkg::*;

    // timing of the display, kept independent of the package
    localparam int LINE_CYCLES      = 228;
    localparam int OAM_CYCLES       = 40;
    localparam int XFER_CYCLES      = 86;
    localparam int HBLANK_CYCLES    = 102;
    localparam int VB_ENTRY_CYCLES  = 8;
    localparam int LINE152_CYCLES   = 28;
    localparam int LINE153_CYCLES   = 200;
    localparam int COUNTDOWN_FLOOR  = -256;
    localparam int TRANSITION_CAP   = 8;
    localparam int VBLANK_LINE      = 144;
    localparam int SHORT_LINE       = 152;
    localparam int OFF_WRAP_LINE    = 154;
    localparam int OFF_OAM_AFTER    = 77;

    localparam logic [2:0] COLOR_MODE_ADDR = 3'd0;

    localparam int TAIL_CYCLES  = 16;
    localparam int HOLD_CYCLES  = 400;
    // longest quiet spell: the long receiver hold plus a sender gap and a tick
    localparam int WATCHDOG_LIMIT = 4000;

    // mirrors the m_tdata layout, lowest field last
    typedef struct packed {
        logic [1:0] pad;
        logic [7:0] status;
        logic [7:0] line;
        logic       frame_done;
        logic       hdma_step;
        logic       frame_begin;
        logic       render_line;
        logic       vblank_irq;
        logic       stat_irq;
    } lcd_event_t;

    typedef struct {
        lcd_event_t ev;
        logic       last;
    } lcd_result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [2:0]           paddr    = '0;
    logic [31:0]          pwdata   = '0;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [KIND_W-1:0]    s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    always #4 aclk = ~aclk;

    lcd_mode_timing_controller dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // ---------------------------------------------------------------- predictor
    bit          color_mode_shadow;
    logic [7:0]  ly;
    logic [7:0]  lyc;
    logic [7:0]  lcdc;
    logic [3:0]  stat_en;
    mode_t       mode;
    int          countdown;
    bit          vblank_due;
    lcd_event_t  cur_ev;
    int          frames_done = 0;
    lcd_result_t expected_results[$];

    function automatic void reset_predictor();
        color_mode_shadow = 1'b0;
        ly = '0;
        lyc = '0;
        lcdc = '0;
        stat_en = '0;
        mode = MODE_OAM;
        countdown = OAM_CYCLES;
        vblank_due = 1'b0;
    endfunction

    function automatic void record_result(bit is_last);
        lcd_result_t r;
        r.ev = cur_ev;
        r.ev.pad = 2'b00;
        r.ev.line = ly;
        r.ev.status = {1'b1, stat_en, 1'b0, mode};
        r.last = is_last;
        if (cur_ev.frame_done)
            frames_done++;
        expected_results.push_back(r);
    endfunction

    function automatic void flag_coincidence();
        if (stat_en[3] && ly == lyc)
            cur_ev.stat_irq = 1'b1;
    endfunction

    function automatic void enter_mode(mode_t m);
        mode = m;
        if ((m == MODE_HBLANK && stat_en[0]) || (m == MODE_VBLANK && stat_en[1]) ||
            (m == MODE_OAM && stat_en[2]))
            cur_ev.stat_irq = 1'b1;
    endfunction

    function automatic void step_mode(bit hdma);
        if (!lcdc[7]) begin
            // display off: plain line stepping, no interrupts
            ly = ly + 8'd1;
            countdown += LINE_CYCLES;
            mode = (ly > OFF_OAM_AFTER) ? MODE_OAM : MODE_HBLANK;
            if (ly >= OFF_WRAP_LINE) begin
                ly = '0;
                cur_ev.frame_begin = 1'b1;
                cur_ev.frame_done = 1'b1;
            end
        end else begin
            case (mode)
                MODE_HBLANK: begin
                    ly = ly + 8'd1;
                    flag_coincidence();
                    if (ly == VBLANK_LINE) begin
                        enter_mode(MODE_VBLANK);
                        vblank_due = 1'b1;
                        countdown += VB_ENTRY_CYCLES;
                    end else begin
                        enter_mode(MODE_OAM);
                        countdown += OAM_CYCLES;
                    end
                end
                MODE_VBLANK: begin
                    if (vblank_due) begin
                        cur_ev.vblank_irq = 1'b1;
                        vblank_due = 1'b0;
                        countdown += LINE_CYCLES;
                    end else if (ly == 0) begin
                        enter_mode(MODE_OAM);
                        countdown += OAM_CYCLES;
                        cur_ev.frame_begin = 1'b1;
                    end else begin
                        if (ly < SHORT_LINE) begin
                            countdown += LINE_CYCLES;
                            ly = ly + 8'd1;
                        end else if (ly == SHORT_LINE) begin
                            countdown += LINE152_CYCLES;
                            ly = ly + 8'd1;
                        end else begin
                            countdown += LINE153_CYCLES;
                            ly = '0;
                            cur_ev.frame_done = 1'b1;
                        end
                        flag_coincidence();
                        enter_mode(MODE_VBLANK);
                    end
                end
                MODE_OAM: begin
                    mode = MODE_XFER;
                    cur_ev.render_line = 1'b1;
                    countdown += XFER_CYCLES;
                end
                default: begin
                    enter_mode(MODE_HBLANK);
                    if (hdma)
                        cur_ev.hdma_step = 1'b1;
                    countdown += HBLANK_CYCLES;
                end
            endcase
        end
    endfunction

    function automatic void predict_item(kind_t kind, logic [5:0] el, logic [7:0] val,
                                         bit hdma);
        int steps;
        steps = 0;
        cur_ev = '0;
        case (kind)
            KIND_TICK: begin
                countdown -= int'(el);
                if (countdown < COUNTDOWN_FLOOR)
                    countdown = COUNTDOWN_FLOOR;
                while (countdown <= 0 && steps < TRANSITION_CAP) begin
                    cur_ev = '0;
                    step_mode(hdma);
                    steps++;
                    record_result(!(countdown <= 0 && steps < TRANSITION_CAP));
                end
                if (steps == 0)
                    record_result(1'b1);
            end
            KIND_LCDC: begin
                if (val[7] && !lcdc[7]) begin
                    mode = MODE_OAM;
                    ly = '0;
                    cur_ev.frame_begin = 1'b1;
                end else if (!val[7] && lcdc[7]) begin
                    mode = MODE_HBLANK;
                    ly = '0;
                    cur_ev.frame_begin = 1'b1;
                end
                lcdc = val;
                record_result(1'b1);
            end
            KIND_STAT: begin
                stat_en = val[6:3];
                // monochrome quirk: any STAT write in vblank off line 0 fires
                if (!color_mode_shadow && lcdc[7] && mode == MODE_VBLANK && ly != 0)
                    cur_ev.stat_irq = 1'b1;
                if (ly == 0 && lyc == 0 && stat_en[3])
                    cur_ev.stat_irq = 1'b1;
                record_result(1'b1);
            end
            default: begin
                lyc = val;
                record_result(1'b1);
            end
        endcase
    endfunction

    // ---------------------------------------------------------------- sender
    int burst_left = 0;
    bit gaps_on = 1'b1;

    task automatic send_item(kind_t kind, logic [5:0] el, logic [7:0] val, bit hdma);
        if (gaps_on && burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 48)
                                                     : $urandom_range(1, 8);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, hdma, val, el};
        s_tuser  <= kind;
        do @(posedge aclk); while (!s_tready);
        predict_item(kind, el, val, hdma);
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    // ---------------------------------------------------------------- APB
    int readback_errors = 0;

    task automatic write_color_mode(bit value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= COLOR_MODE_ADDR;
        pwdata  <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        color_mode_shadow = value;
        // back-to-back read of the same register
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== 32'(value)) begin
            readback_errors++;
            $display("%0t: color_mode read back expected %0h actual %0h",
                     $time, value, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ---------------------------------------------------------------- receiver
    int rx_hold_request = 0;
    int rx_holds_served = 0;
    int rx_hold_left = 0;
    int rx_phase = 0;
    int rx_phase_left = 0;
    int rx_tick = 0;

    always @(posedge aclk) begin
        if (rx_hold_request != rx_holds_served) begin
            rx_holds_served = rx_hold_request;
            rx_hold_left = HOLD_CYCLES;
        end
        if (rx_phase_left == 0) begin
            rx_phase = $urandom_range(0, 3);
            rx_phase_left = $urandom_range(16, 96);
        end
        rx_phase_left--;
        rx_tick++;
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (rx_phase)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 1) == 1);
                2: m_tready <= (rx_tick % 4 == 0);
                default: m_tready <= ($urandom_range(0, 6) != 0);
            endcase
        end
    end

    // ---------------------------------------------------------------- checker
    int mismatches = 0;

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            if (mismatches < 50)
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : result_check
        lcd_event_t  got;
        lcd_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_results.size() == 0) begin
                if (mismatches < 50)
                    $display("%0t: result with none expected, expected none actual %h",
                             $time, m_tdata);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                check_field("stat_irq",     want.ev.stat_irq,    got.stat_irq);
                check_field("vblank_irq",   want.ev.vblank_irq,  got.vblank_irq);
                check_field("render_line",  want.ev.render_line, got.render_line);
                check_field("frame_begin",  want.ev.frame_begin, got.frame_begin);
                check_field("hdma_step",    want.ev.hdma_step,   got.hdma_step);
                check_field("frame_done",   want.ev.frame_done,  got.frame_done);
                check_field("line_number",  want.ev.line,        got.line);
                check_field("status_value", want.ev.status,      got.status);
                check_field("tdata pad",    want.ev.pad,         got.pad);
                check_field("tlast",        want.last,           m_tlast);
            end
        end
    end

    // ---------------------------------------------------------------- watchdog
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    // ---------------------------------------------------------------- tests
    // extremes of every field, all four kinds, idle ticks, display on/off edges,
    // the line-0 compare hit on a STAT write
    task automatic test_directed_items();
        send_item(KIND_TICK, 6'd0, 8'h00, 1'b0);    // nothing elapses, no step
        send_item(KIND_TICK, 6'd63, 8'hFF, 1'b1);   // display off, one line step
        send_item(KIND_LYC, 6'd0, 8'hFF, 1'b0);
        send_item(KIND_LYC, 6'd63, 8'h00, 1'b1);
        send_item(KIND_STAT, 6'd0, 8'hFF, 1'b0);
        send_item(KIND_STAT, 6'd0, 8'h00, 1'b0);
        send_item(KIND_LCDC, 6'd0, 8'h80, 1'b0);    // display on
        send_item(KIND_STAT, 6'd0, 8'h40, 1'b0);    // LY == LYC == 0 on write
        send_item(KIND_STAT, 6'd0, 8'h78, 1'b1);
        repeat (5) send_item(KIND_TICK, 6'd63, 8'h00, 1'b1);
        send_item(KIND_LYC, 6'd0, 8'h01, 1'b0);
        repeat (3) send_item(KIND_TICK, 6'd63, 8'h00, 1'b1);
        send_item(KIND_LCDC, 6'd0, 8'h7F, 1'b0);    // display off
        send_item(KIND_LCDC, 6'd0, 8'h00, 1'b0);    // no edge on bit 7
        send_item(KIND_LCDC, 6'd0, 8'hFF, 1'b0);    // back on
        send_item(KIND_STAT, 6'd21, 8'hAA, 1'b0);
        send_item(KIND_STAT, 6'd42, 8'h55, 1'b1);
        send_item(KIND_LYC, 6'd21, 8'hAA, 1'b0);
        send_item(KIND_LYC, 6'd42, 8'h55, 1'b1);
    endtask

    // mostly ticks with random content; STAT writes are denser in vblank
    task automatic send_walk_item();
        int pick;
        pick = $urandom_range(0, 99);
        if ((mode == MODE_VBLANK && pick < 20) || pick < 4)
            send_item(KIND_STAT, 6'($urandom), 8'($urandom), 1'($urandom));
        else if (pick < 8)
            send_item(KIND_LYC, 6'($urandom), 8'($urandom_range(0, 153)), 1'($urandom));
        else if (pick < 18)
            send_item(KIND_TICK, 6'($urandom_range(0, 63)), 8'($urandom), 1'($urandom));
        else
            send_item(KIND_TICK, 6'($urandom_range(32, 63)), 8'($urandom), 1'($urandom));
    endtask

    task automatic test_display_off_walk();
        int start_frames;
        int n;
        send_item(KIND_LCDC, 6'($urandom), 8'($urandom_range(0, 127)), 1'b0);
        start_frames = frames_done;
        n = 0;
        while (frames_done == start_frames && n < 50) begin
            if ($urandom_range(0, 19) == 0)
                send_item(KIND_STAT, 6'($urandom), 8'($urandom), 1'($urandom));
            else
                send_item(KIND_TICK, 6'($urandom_range(40, 63)), 8'($urandom),
                          1'($urandom));
            n++;
        end
    endtask

    // display-on walk: first stretch in monochrome, then colour
    task automatic test_frame_walk();
        int start_frames;
        int n;
        drain_results();
        write_color_mode(1'b0);
        send_item(KIND_LCDC, 6'($urandom), 8'($urandom_range(128, 255)), 1'b0);
        n = 0;
        while (!(mode == MODE_VBLANK && ly >= 148) && n < 50) begin
            send_walk_item();
            n++;
        end
        drain_results();
        write_color_mode(1'b1);
        start_frames = frames_done;
        n = 0;
        while (frames_done == start_frames && n < 20) begin
            send_walk_item();
            n++;
        end
        repeat (10) send_walk_item();
    endtask

    task automatic test_random_mix();
        int pick;
        for (int setting = 0; setting < 2; setting++) begin
            drain_results();
            write_color_mode(setting == 0 ? 1'b0 : 1'b1);
            repeat (40) begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    send_item(KIND_TICK, 6'($urandom), 8'($urandom), 1'($urandom));
                else if (pick < 78)
                    send_item(KIND_LCDC, 6'($urandom), 8'($urandom), 1'($urandom));
                else if (pick < 89)
                    send_item(KIND_STAT, 6'($urandom), 8'($urandom), 1'($urandom));
                else if (pick < 94)
                    send_item(KIND_LYC, 6'($urandom), 8'($urandom), 1'($urandom));
                else
                    send_item(KIND_LYC, 6'($urandom), ly + 8'($urandom_range(0, 2)),
                              1'($urandom));
            end
        end
    endtask

    // receiver holds off while items keep coming at full rate
    task automatic test_output_backpressure();
        gaps_on = 1'b0;
        rx_hold_request++;
        repeat (40) begin
            if ($urandom_range(0, 4) == 0)
                send_item(KIND_STAT, 6'($urandom), 8'($urandom), 1'($urandom));
            else
                send_item(KIND_TICK, 6'($urandom), 8'($urandom), 1'($urandom));
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        reset_predictor();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_color_mode(1'b0);
        test_directed_items();
        test_display_off_walk();
        test_frame_walk();
        test_random_mix();
        test_output_backpressure();
        drain_results();
        if (mismatches == 0 && readback_errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
